// ===== rtl/core/ptok_pkg.sv =====
// Shared types, character codes and lexer state encoding for the properties-file tokenizer.
package ptok_pkg;

    // Width of one text character as the lexer sees it.
    localparam int CHAR_BITS = 8;

    typedef logic [CHAR_BITS-1:0] char_t;

    // Character codes the lexer reacts to.
    localparam char_t CH_HASH   = char_t'(8'h23);
    localparam char_t CH_BANG   = char_t'(8'h21);
    localparam char_t CH_COLON  = char_t'(8'h3A);
    localparam char_t CH_EQUAL  = char_t'(8'h3D);
    localparam char_t CH_TAB    = char_t'(8'h09);
    localparam char_t CH_CR     = char_t'(8'h0D);
    localparam char_t CH_LF     = char_t'(8'h0A);
    localparam char_t CH_SPACE  = char_t'(8'h20);
    localparam char_t CH_BSLASH = char_t'(8'h5C);

    // Input item flag values.
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_EOS  = 1'b1;

    // Token kinds.
    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_PAIR  = 2'd2
    } kind_t;

    // Lexer states, one-hot.
    typedef enum logic [10:0] {
        ST_BEGIN      = 11'b000_0000_0001,
        ST_KEY        = 11'b000_0000_0010,
        ST_KEY_ESC    = 11'b000_0000_0100,
        ST_KEY_CONT   = 11'b000_0000_1000,
        ST_KEY_CONT2  = 11'b000_0001_0000,
        ST_DELIM      = 11'b000_0010_0000,
        ST_ELEM       = 11'b000_0100_0000,
        ST_ELEM_ESC   = 11'b000_1000_0000,
        ST_ELEM_CONT  = 11'b001_0000_0000,
        ST_ELEM_CONT2 = 11'b010_0000_0000,
        ST_COMMENT    = 11'b100_0000_0000
    } lex_state_t;

    // One accepted input item.
    typedef struct packed {
        logic  func;
        char_t ch;
    } item_t;

    // Token produced for one item.
    typedef struct packed {
        logic  valid;
        kind_t kind;
        char_t ch;
    } token_t;

endpackage

// ===== rtl/core/ptok_in_stage.sv =====
// Input register stage that holds one accepted character or end-of-stream transaction.
module ptok_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ptok_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output ptok_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    ptok_pkg::item_t item_reg;

    // The stage takes a new transaction when empty or when its item moves on.
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/core/ptok_lexer.sv =====
// Lexer state and the combinational next-state and token logic for one item.
module ptok_lexer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  ptok_pkg::item_t  item,
    output ptok_pkg::token_t token
);

    typedef struct packed {
        ptok_pkg::lex_state_t state;
        logic                 key_nonempty;
        ptok_pkg::token_t     token;
    } lex_out_t;

    ptok_pkg::lex_state_t state_reg;
    ptok_pkg::lex_state_t state_next;
    logic                 nonempty_reg;
    logic                 nonempty_next;
    lex_out_t             step;

    // Walk the state changes that do not consume the character, then the one that does.
    // At most three passes are needed: continuation, continuation, key.
    function automatic lex_out_t lex_char(ptok_pkg::lex_state_t cur, logic nonempty,
                                          ptok_pkg::char_t c);
        lex_out_t             r;
        ptok_pkg::lex_state_t s;
        logic                 done;
        logic                 blank;
        logic                 eol;
        logic                 sep;
        r.state        = cur;
        r.key_nonempty = nonempty;
        r.token        = '0;
        s              = cur;
        done           = 1'b0;
        blank          = (c == ptok_pkg::CH_SPACE) || (c == ptok_pkg::CH_TAB);
        eol            = (c == ptok_pkg::CH_LF) || (c == ptok_pkg::CH_CR);
        sep            = blank || (c == ptok_pkg::CH_COLON) || (c == ptok_pkg::CH_EQUAL);
        for (int hop = 0; hop < 3; hop++) begin
            if (!done) begin
                case (s)
                    ptok_pkg::ST_KEY: begin
                        done = 1'b1;
                        if (c == ptok_pkg::CH_BSLASH) begin
                            r.state = ptok_pkg::ST_KEY_ESC;
                        end else if (sep) begin
                            r.state = ptok_pkg::ST_DELIM;
                        end else if (eol) begin
                            r.state        = ptok_pkg::ST_BEGIN;
                            r.key_nonempty = 1'b0;
                            r.token.valid  = 1'b1;
                            r.token.kind   = ptok_pkg::KIND_PAIR;
                        end else begin
                            r.state        = ptok_pkg::ST_KEY;
                            r.key_nonempty = 1'b1;
                            r.token.valid  = 1'b1;
                            r.token.kind   = ptok_pkg::KIND_KEY;
                            r.token.ch     = c;
                        end
                    end
                    ptok_pkg::ST_KEY_ESC: begin
                        done = 1'b1;
                        if (c == ptok_pkg::CH_LF) begin
                            r.state = ptok_pkg::ST_KEY_CONT;
                        end else if (c == ptok_pkg::CH_CR) begin
                            r.state = ptok_pkg::ST_KEY_CONT2;
                        end else begin
                            // Escaped characters are taken literally.
                            r.state        = ptok_pkg::ST_KEY;
                            r.key_nonempty = 1'b1;
                            r.token.valid  = 1'b1;
                            r.token.kind   = ptok_pkg::KIND_KEY;
                            r.token.ch     = c;
                        end
                    end
                    ptok_pkg::ST_KEY_CONT: begin
                        if (blank) begin
                            done    = 1'b1;
                            r.state = s;
                        end else begin
                            s = ptok_pkg::ST_KEY;
                        end
                    end
                    ptok_pkg::ST_KEY_CONT2: begin
                        if (c == ptok_pkg::CH_LF) begin
                            done    = 1'b1;
                            r.state = ptok_pkg::ST_KEY_CONT;
                        end else begin
                            s = ptok_pkg::ST_KEY_CONT;
                        end
                    end
                    ptok_pkg::ST_DELIM: begin
                        if (sep) begin
                            done    = 1'b1;
                            r.state = s;
                        end else begin
                            s = ptok_pkg::ST_ELEM;
                        end
                    end
                    ptok_pkg::ST_ELEM: begin
                        done = 1'b1;
                        if (c == ptok_pkg::CH_BSLASH) begin
                            r.state = ptok_pkg::ST_ELEM_ESC;
                        end else if (eol) begin
                            r.state        = ptok_pkg::ST_BEGIN;
                            r.key_nonempty = 1'b0;
                            r.token.valid  = 1'b1;
                            r.token.kind   = ptok_pkg::KIND_PAIR;
                        end else begin
                            r.state       = ptok_pkg::ST_ELEM;
                            r.token.valid = 1'b1;
                            r.token.kind  = ptok_pkg::KIND_VALUE;
                            r.token.ch    = c;
                        end
                    end
                    ptok_pkg::ST_ELEM_ESC: begin
                        done = 1'b1;
                        if (c == ptok_pkg::CH_LF) begin
                            r.state = ptok_pkg::ST_ELEM_CONT;
                        end else if (c == ptok_pkg::CH_CR) begin
                            r.state = ptok_pkg::ST_ELEM_CONT2;
                        end else begin
                            // Escape letters are passed through untranslated.
                            r.state       = ptok_pkg::ST_ELEM;
                            r.token.valid = 1'b1;
                            r.token.kind  = ptok_pkg::KIND_VALUE;
                            r.token.ch    = c;
                        end
                    end
                    ptok_pkg::ST_ELEM_CONT: begin
                        if (blank) begin
                            done    = 1'b1;
                            r.state = s;
                        end else begin
                            s = ptok_pkg::ST_ELEM;
                        end
                    end
                    ptok_pkg::ST_ELEM_CONT2: begin
                        if (c == ptok_pkg::CH_LF) begin
                            done    = 1'b1;
                            r.state = ptok_pkg::ST_ELEM_CONT;
                        end else begin
                            s = ptok_pkg::ST_ELEM_CONT;
                        end
                    end
                    ptok_pkg::ST_COMMENT: begin
                        done    = 1'b1;
                        r.state = eol ? ptok_pkg::ST_BEGIN : ptok_pkg::ST_COMMENT;
                    end
                    default: begin
                        // Line begin; any other code behaves the same.
                        if (blank || eol) begin
                            done    = 1'b1;
                            r.state = ptok_pkg::ST_BEGIN;
                        end else if ((c == ptok_pkg::CH_HASH) || (c == ptok_pkg::CH_BANG)) begin
                            done    = 1'b1;
                            r.state = ptok_pkg::ST_COMMENT;
                        end else begin
                            s = ptok_pkg::ST_KEY;
                        end
                    end
                endcase
            end
        end
        return r;
    endfunction

    // End of stream closes a pair only when a key character was seen.
    always_comb begin
        if (item.func == ptok_pkg::FUNC_EOS) begin
            step.state        = ptok_pkg::ST_BEGIN;
            step.key_nonempty = 1'b0;
            step.token.valid  = nonempty_reg;
            step.token.kind   = ptok_pkg::KIND_PAIR;
            step.token.ch     = '0;
        end else begin
            step = lex_char(state_reg, nonempty_reg, item.ch);
        end
    end

    assign token = step.token;

    always_comb begin
        state_next    = state_reg;
        nonempty_next = nonempty_reg;
        if (advance) begin
            state_next    = step.state;
            nonempty_next = step.key_nonempty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ptok_pkg::ST_BEGIN;
            nonempty_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nonempty_reg <= nonempty_next;
        end
    end

endmodule

// ===== rtl/core/ptok_out_stage.sv =====
// Result register that holds one token until the downstream side takes it.
module ptok_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  ptok_pkg::token_t token,
    output logic             space,
    output logic             m_valid,
    input  logic             m_ready,
    output ptok_pkg::kind_t  m_kind,
    output ptok_pkg::char_t  m_char
);

    logic            valid_reg;
    logic            valid_next;
    ptok_pkg::kind_t kind_reg;
    ptok_pkg::char_t char_reg;

    // The register can be loaded when empty or when its token leaves this cycle.
    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_kind  = kind_reg;
    assign m_char  = char_reg;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (advance) begin
            valid_next = token.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && token.valid) begin
            kind_reg <= token.kind;
            char_reg <= token.ch;
        end
    end

endmodule

// ===== rtl/core/properties_file_tokenizer.sv =====
// Top level of the properties-file tokenizer: input stage, lexer and result register.
// The tokenizer takes one character, or an end-of-stream marker, per cycle unless a result
// waits on a stalled receiver, and returns at most one token for it: a key character, a value
// character or an end-of-pair mark. With the result side ready it sustains one transaction per
// cycle; an accepted character is held in the input register, then the lexer logic turns it
// into a token in the result register. Characters that give no token produce no transaction.
// The rate is set by the lexer state register, which is updated once per character.
module properties_file_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] ch
    input  logic [0:0] s_tuser,  // [0] func (1 = end of stream)
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // [7:0] out_char
    output logic [1:0] m_tuser   // [1:0] kind
);

    ptok_pkg::item_t  s_item;
    ptok_pkg::item_t  item;
    logic             item_valid;
    logic             space;
    logic             advance;
    ptok_pkg::token_t token;
    ptok_pkg::kind_t  m_kind;
    ptok_pkg::char_t  m_char;

    assign s_item.func = s_tuser[0];
    assign s_item.ch   = s_tdata[ptok_pkg::CHAR_BITS-1:0];

    // An item moves through the lexer when the result register has room.
    assign advance = item_valid && space;

    ptok_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ptok_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .token   (token)
    );

    ptok_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .token   (token),
        .space   (space),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_kind  (m_kind),
        .m_char  (m_char)
    );

    assign m_tuser = m_kind;
    assign m_tdata = 8'(m_char);

endmodule

// ===== rtl/core/ptok_checker.sv =====
// Port-level checks for the properties-file tokenizer and their binding to the top level.
module ptok_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result transaction stays offered and unchanged.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    // The input side is held off only while a result waits on a stalled receiver.
    a_in_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // Only the three token kinds are ever produced.
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ptok_pkg::KIND_KEY) || (m_tuser == ptok_pkg::KIND_VALUE)
                     || (m_tuser == ptok_pkg::KIND_PAIR))
        else $error("illegal token kind");

    // An end-of-pair mark carries no character.
    a_pair_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ptok_pkg::KIND_PAIR) |-> (m_tdata == 8'd0))
        else $error("end-of-pair mark with a nonzero character");

endmodule

bind properties_file_tokenizer ptok_checker u_ptok_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/tb_properties_file_tokenizer.sv =====
`timescale 1ns / 100ps
// Testbench for the properties-file tokenizer: directed and random text against a lexer predictor.
module tb_properties_file_tokenizer;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 300;
    localparam int MAX_REPORTS    = 10;

    // One expected token.
    typedef struct packed {
        ptok_pkg::kind_t kind;
        ptok_pkg::char_t ch;
    } token_exp_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // [7:0] ch
    logic [0:0] s_tuser  = '0;   // [0] func (1 = end of stream)
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [7:0] out_char
    logic [1:0] m_tuser;         // [1:0] kind

    // Text waiting to be sent and tokens waiting to come back.
    ptok_pkg::item_t text_q[$];
    token_exp_t      token_q[$];

    // Lexer state as predicted by the testbench.
    ptok_pkg::lex_state_t lex_st   = ptok_pkg::ST_BEGIN;
    bit                   key_seen = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int fault_count    = 0;
    int reports        = 0;
    int phase_items    = 0;

    token_exp_t      next_tok;
    token_exp_t      exp_tok;
    ptok_pkg::item_t next_item;

    properties_file_tokenizer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Advance the lexer by one input transaction; returns 1 when a token results.
    function automatic bit lex_char(input logic is_eos, input ptok_pkg::char_t c,
                                    output token_exp_t tok);
        bit blank;
        bit eol;
        bit sep;
        bit had_key;
        blank = (c == ptok_pkg::CH_SPACE) || (c == ptok_pkg::CH_TAB);
        eol   = (c == ptok_pkg::CH_LF) || (c == ptok_pkg::CH_CR);
        sep   = blank || (c == ptok_pkg::CH_COLON) || (c == ptok_pkg::CH_EQUAL);
        tok.kind = ptok_pkg::KIND_PAIR;
        tok.ch   = '0;
        if (is_eos == ptok_pkg::FUNC_EOS) begin
            had_key  = key_seen;
            lex_st   = ptok_pkg::ST_BEGIN;
            key_seen = 1'b0;
            return had_key;
        end
        // A character may move through a few states before it is consumed.
        for (int hop = 0; hop < 4; hop++) begin
            case (lex_st)
                ptok_pkg::ST_KEY: begin
                    if (c == ptok_pkg::CH_BSLASH) begin
                        lex_st = ptok_pkg::ST_KEY_ESC;
                        return 1'b0;
                    end
                    if (sep) begin
                        lex_st = ptok_pkg::ST_DELIM;
                        return 1'b0;
                    end
                    if (eol) begin
                        lex_st   = ptok_pkg::ST_BEGIN;
                        key_seen = 1'b0;
                        return 1'b1;
                    end
                    key_seen = 1'b1;
                    tok.kind = ptok_pkg::KIND_KEY;
                    tok.ch   = c;
                    return 1'b1;
                end
                ptok_pkg::ST_KEY_ESC: begin
                    if (c == ptok_pkg::CH_LF) begin
                        lex_st = ptok_pkg::ST_KEY_CONT;
                        return 1'b0;
                    end
                    if (c == ptok_pkg::CH_CR) begin
                        lex_st = ptok_pkg::ST_KEY_CONT2;
                        return 1'b0;
                    end
                    lex_st   = ptok_pkg::ST_KEY;
                    key_seen = 1'b1;
                    tok.kind = ptok_pkg::KIND_KEY;
                    tok.ch   = c;
                    return 1'b1;
                end
                ptok_pkg::ST_KEY_CONT: begin
                    if (blank) begin
                        return 1'b0;
                    end
                    lex_st = ptok_pkg::ST_KEY;
                end
                ptok_pkg::ST_KEY_CONT2: begin
                    lex_st = ptok_pkg::ST_KEY_CONT;
                    if (c == ptok_pkg::CH_LF) begin
                        return 1'b0;
                    end
                end
                ptok_pkg::ST_DELIM: begin
                    if (sep) begin
                        return 1'b0;
                    end
                    lex_st = ptok_pkg::ST_ELEM;
                end
                ptok_pkg::ST_ELEM: begin
                    if (c == ptok_pkg::CH_BSLASH) begin
                        lex_st = ptok_pkg::ST_ELEM_ESC;
                        return 1'b0;
                    end
                    if (eol) begin
                        lex_st   = ptok_pkg::ST_BEGIN;
                        key_seen = 1'b0;
                        return 1'b1;
                    end
                    tok.kind = ptok_pkg::KIND_VALUE;
                    tok.ch   = c;
                    return 1'b1;
                end
                ptok_pkg::ST_ELEM_ESC: begin
                    if (c == ptok_pkg::CH_LF) begin
                        lex_st = ptok_pkg::ST_ELEM_CONT;
                        return 1'b0;
                    end
                    if (c == ptok_pkg::CH_CR) begin
                        lex_st = ptok_pkg::ST_ELEM_CONT2;
                        return 1'b0;
                    end
                    lex_st   = ptok_pkg::ST_ELEM;
                    tok.kind = ptok_pkg::KIND_VALUE;
                    tok.ch   = c;
                    return 1'b1;
                end
                ptok_pkg::ST_ELEM_CONT: begin
                    if (blank) begin
                        return 1'b0;
                    end
                    lex_st = ptok_pkg::ST_ELEM;
                end
                ptok_pkg::ST_ELEM_CONT2: begin
                    lex_st = ptok_pkg::ST_ELEM_CONT;
                    if (c == ptok_pkg::CH_LF) begin
                        return 1'b0;
                    end
                end
                ptok_pkg::ST_COMMENT: begin
                    if (eol) begin
                        lex_st = ptok_pkg::ST_BEGIN;
                    end
                    return 1'b0;
                end
                default: begin
                    if (blank || eol) begin
                        lex_st = ptok_pkg::ST_BEGIN;
                        return 1'b0;
                    end
                    if ((c == ptok_pkg::CH_HASH) || (c == ptok_pkg::CH_BANG)) begin
                        lex_st = ptok_pkg::ST_COMMENT;
                        return 1'b0;
                    end
                    lex_st = ptok_pkg::ST_KEY;
                end
            endcase
        end
        return 1'b0;
    endfunction

    task automatic push_char(input ptok_pkg::char_t c);
        ptok_pkg::item_t it;
        it.func = ptok_pkg::FUNC_CHAR;
        it.ch   = c;
        text_q.insert(text_q.size(), it);
        phase_items++;
    endtask

    // End of stream carries a random, ignored character.
    task automatic push_eos();
        ptok_pkg::item_t it;
        it.func = ptok_pkg::FUNC_EOS;
        it.ch   = ptok_pkg::char_t'($urandom_range(255));
        text_q.insert(text_q.size(), it);
        phase_items++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(ptok_pkg::char_t'(s[i]));
        end
    endtask

    // Line break as LF, CR or CR LF.
    task automatic push_newline();
        int sel;
        sel = $urandom_range(2);
        if (sel == 0) begin
            push_char(ptok_pkg::CH_LF);
        end else begin
            push_char(ptok_pkg::CH_CR);
            if (sel == 2) begin
                push_char(ptok_pkg::CH_LF);
            end
        end
    endtask

    task automatic push_blanks(input int max_n);
        int n;
        n = $urandom_range(max_n);
        for (int i = 0; i < n; i++) begin
            push_char($urandom_range(1) ? ptok_pkg::CH_SPACE : ptok_pkg::CH_TAB);
        end
    endtask

    // Mostly printable characters other than backslash, colon and equals, sometimes any byte.
    function automatic ptok_pkg::char_t plain_char();
        ptok_pkg::char_t c;
        if ($urandom_range(9) == 0) begin
            return ptok_pkg::char_t'($urandom_range(255));
        end
        do begin
            c = ptok_pkg::char_t'($urandom_range(33, 126));
        end while ((c == ptok_pkg::CH_BSLASH) || (c == ptok_pkg::CH_COLON)
                   || (c == ptok_pkg::CH_EQUAL));
        return c;
    endfunction

    // Key or value text with occasional escapes and line continuations.
    task automatic push_field(input int max_len);
        int n;
        n = $urandom_range(max_len);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(6) == 0) begin
                push_char(ptok_pkg::CH_BSLASH);
                if ($urandom_range(1)) begin
                    push_newline();
                    push_blanks(2);
                end else begin
                    push_char(ptok_pkg::char_t'($urandom_range(255)));
                end
            end else begin
                push_char(plain_char());
            end
        end
    endtask

    // One random line: mostly well-formed pairs, plus comments, noise and stream ends.
    task automatic push_random_line();
        int sel;
        int n;
        sel = $urandom_range(99);
        if (sel < 10) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                push_char(ptok_pkg::char_t'($urandom_range(255)));
            end
        end else if (sel < 20) begin
            push_blanks(2);
            push_char($urandom_range(1) ? ptok_pkg::CH_HASH : ptok_pkg::CH_BANG);
            n = $urandom_range(6);
            for (int i = 0; i < n; i++) begin
                push_char(plain_char());
            end
            push_newline();
        end else if (sel < 25) begin
            push_eos();
        end else begin
            push_blanks(2);
            push_field(6);
            push_blanks(1);
            case ($urandom_range(2))
                0: push_char(ptok_pkg::CH_COLON);
                1: push_char(ptok_pkg::CH_EQUAL);
                default: push_char($urandom_range(1) ? ptok_pkg::CH_SPACE : ptok_pkg::CH_TAB);
            endcase
            push_blanks(2);
            push_field(8);
            if ($urandom_range(9) == 0) begin
                push_eos();
            end else begin
                push_newline();
            end
        end
    endtask

    // Wait until every queued item is sent and every expected token has arrived.
    task automatic wait_drained();
        while ((text_q.size() != 0) || s_tvalid || (token_q.size() != 0)) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_items    = 0;
        while (phase_items < PHASE_ITEMS) begin
            push_random_line();
        end
        wait_drained();
    endtask

    task automatic note_mismatch(input string what, input token_exp_t want_tok);
        fault_count++;
        if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: %s: expected kind %0d char 0x%02h, got kind %0d char 0x%02h",
                     $realtime, what, want_tok.kind, want_tok.ch, m_tuser, m_tdata);
        end
    endtask

    // Sender: predicts each accepted transaction and offers the next item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (lex_char(s_tuser[0], s_tdata, next_tok)) begin
                    token_q.insert(token_q.size(), next_tok);
                end
            end
            if (!s_tvalid || s_tready) begin
                if ((text_q.size() != 0) && ($urandom_range(99) >= send_idle_pct)) begin
                    next_item = text_q.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= next_item.ch;
                    s_tuser   <= next_item.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, and a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Token checker and watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (token_q.size() == 0) begin
                    note_mismatch("token with none expected", '0);
                end else begin
                    exp_tok = token_q.pop_front();
                    if ((m_tuser != exp_tok.kind) || (m_tdata != exp_tok.ch)) begin
                        note_mismatch("token mismatch", exp_tok);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else if ((text_q.size() != 0) || s_tvalid || (token_q.size() != 0)) begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed text: comments, blanks, escapes, continuations, delimiters, stream ends.
        push_char(ptok_pkg::CH_HASH);
        push_char(ptok_pkg::CH_LF);
        push_char(ptok_pkg::CH_TAB);
        push_char(ptok_pkg::CH_BANG);
        push_char(ptok_pkg::CH_CR);
        push_char(ptok_pkg::CH_SPACE);
        push_text("k");
        push_char(ptok_pkg::CH_BSLASH);
        push_text("q");
        push_char(ptok_pkg::CH_BSLASH);
        push_char(ptok_pkg::CH_LF);
        push_char(ptok_pkg::CH_SPACE);
        push_char(8'hFF);
        push_char(ptok_pkg::CH_BSLASH);
        push_char(ptok_pkg::CH_CR);
        push_text("a");
        push_char(ptok_pkg::CH_SPACE);
        push_char(ptok_pkg::CH_COLON);
        push_char(ptok_pkg::CH_BSLASH);
        push_text("t");
        push_char(ptok_pkg::CH_BSLASH);
        push_text("n");
        push_char(ptok_pkg::CH_BSLASH);
        push_text("r");
        push_char(ptok_pkg::CH_BSLASH);
        push_char(ptok_pkg::CH_CR);
        push_char(ptok_pkg::CH_LF);
        push_char(ptok_pkg::CH_TAB);
        push_char(8'h00);
        push_char(ptok_pkg::CH_BSLASH);
        push_char(ptok_pkg::CH_LF);
        push_text("x");
        push_char(ptok_pkg::CH_CR);
        // Empty key closed by a newline, then stream ends with and without a key.
        push_char(ptok_pkg::CH_EQUAL);
        push_char(ptok_pkg::CH_LF);
        push_eos();
        push_text("y");
        push_char(ptok_pkg::CH_LF);
        push_text("z");
        push_eos();

        // Full rate, with one long receiver hold-off while the sender keeps offering.
        phase_items    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (phase_items < PHASE_ITEMS) begin
            push_random_line();
        end
        @(posedge aclk);
        hold_requests = hold_requests + 1;
        wait_drained();

        run_phase(84, 0);
        run_phase(0, 84);
        run_phase(12, 12);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if ((fault_count == 0) && (token_q.size() == 0)) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
